[hw/rtl/rn48_pkg.sv]
// Package: shared types and constants of the node48 child table.
`default_nettype none
package rn48_pkg;

  localparam int unsigned KEY_W   = 8;
  localparam int unsigned KEYS    = 256;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned FIELD_W = 6;

  localparam logic [FIELD_W-1:0] SHRINK_RESET = 6'd12;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_GROW    = 3'd1,
    ST_SHRINK  = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_PRESENT = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_LOOK = 2'd1,
    S_FREE = 2'd2
  } state_e;

endpackage : rn48_pkg
`default_nettype wire

[hw/rtl/rn48_if.sv]
// Interfaces: request and response channels of the node48 child table.
`default_nettype none
interface rn48_req_if
  import rn48_pkg::*;
#(
  parameter int unsigned CHILD_WIDTH = 48
);
  logic                   valid;
  logic                   ready;
  logic [OP_W-1:0]        operation;
  logic [KEY_W-1:0]       key_byte;
  logic [CHILD_WIDTH-1:0] child_ref;

  modport source (output valid, output operation, output key_byte, output child_ref,
                  input ready);
  modport sink   (input valid, input operation, input key_byte, input child_ref,
                  output ready);
endinterface : rn48_req_if

interface rn48_rsp_if
  import rn48_pkg::*;
#(
  parameter int unsigned CHILD_WIDTH = 48
);
  logic                   valid;
  logic                   ready;
  logic [STAT_W-1:0]      status;
  logic [FIELD_W-1:0]     slot_used;
  logic [CHILD_WIDTH-1:0] freed_child;
  logic [FIELD_W-1:0]     child_count;

  modport source (output valid, output status, output slot_used, output freed_child,
                  output child_count, input ready);
  modport sink   (input valid, input status, input slot_used, input freed_child,
                  input child_count, output ready);
endinterface : rn48_rsp_if
`default_nettype wire

[hw/rtl/radix_node48_child_table.sv]
// Top level: node48 child table with key map and slot memories.
//
//  channel  dir  handshake      word
//  req_i    in   valid/ready    operation, key_byte, child_ref
//  rsp_o    out  valid/ready    status, slot_used, freed_child, child_count
//  cfg      in   cfg_we_i       shrink limit (cfg_wdata_i)
//
// Insert, clear, no-op and a delete of an absent key are accepted with a key
// map read, then decided and written back. A delete that finds its key also
// reads the freed child from the slot memory after the map lookup.
// Reset empties the map at once through per-key valid bits.
// A result waits in the output register while a new word is accepted; the
// block holds in its last state while that register is full and not taken.
`default_nettype none
module radix_node48_child_table
  import rn48_pkg::*;
#(
  parameter int unsigned SLOTS       = 48,
  parameter int unsigned CHILD_WIDTH = 48
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  rn48_req_if.sink          req_i,
  rn48_rsp_if.source        rsp_o,
  input  wire               cfg_we_i,
  input  wire [FIELD_W-1:0] cfg_wdata_i
);

  localparam int unsigned IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned SLOT_W = $clog2(SLOTS + 1);
  localparam logic [SLOT_W-1:0] SLOTS_C = SLOT_W'(SLOTS);

  // Storage
  logic [IDX_W-1:0]       map_mem [KEYS];
  logic [CHILD_WIDTH-1:0] child_mem [SLOTS];

  state_e                 state_q, state_d;
  logic [KEYS-1:0]        map_vld_q, map_vld_d;
  logic [SLOTS-1:0]       busy_q, busy_d;
  logic [SLOT_W-1:0]      count_q, count_d;
  logic [FIELD_W-1:0]     thr_q;
  logic [SLOT_W-1:0]      first_free_q, first_free_d;

  op_e                    op_q;
  logic [KEY_W-1:0]       key_q;
  logic [CHILD_WIDTH-1:0] child_q;
  logic [IDX_W-1:0]       map_rd_q;
  logic                   present_q;
  logic [CHILD_WIDTH-1:0] child_rd_q;

  logic                   rsp_vld_q, rsp_vld_d;
  status_e                rsp_stat_q, rsp_stat_d;
  logic [FIELD_W-1:0]     rsp_slot_q, rsp_slot_d;
  logic [CHILD_WIDTH-1:0] rsp_freed_q, rsp_freed_d;
  logic [FIELD_W-1:0]     rsp_cnt_q, rsp_cnt_d;

  logic                   accept;
  logic                   can_load;
  logic                   map_we, slot_we, slot_re;
  logic [IDX_W-1:0]       ins_slot;
  logic                   ins_full;
  logic [SLOT_W-1:0]      cnt_dec;

  assign accept   = req_i.valid && req_i.ready;
  assign can_load = !rsp_vld_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE);

  assign rsp_o.valid       = rsp_vld_q;
  assign rsp_o.status      = rsp_stat_q;
  assign rsp_o.slot_used   = rsp_slot_q;
  assign rsp_o.freed_child = rsp_freed_q;
  assign rsp_o.child_count = rsp_cnt_q;

  // Lowest free slot, registered from busy, which settles before the next lookup uses it
  always_comb begin
    first_free_d = SLOTS_C;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        first_free_d = SLOT_W'(i);
      end
    end
  end

  // Slot choice: the one numbered by count if free, else the lowest free
  always_comb begin
    ins_full = 1'b0;
    ins_slot = first_free_q[IDX_W-1:0];
    if (count_q >= SLOTS_C) begin
      ins_full = 1'b1;
    end else if (!busy_q[count_q[IDX_W-1:0]]) begin
      ins_slot = count_q[IDX_W-1:0];
    end else if (first_free_q == SLOTS_C) begin
      ins_full = 1'b1;
    end
  end

  assign cnt_dec = (count_q != '0) ? (count_q - SLOT_W'(1)) : count_q;

  always_comb begin
    state_d     = state_q;
    map_vld_d   = map_vld_q;
    busy_d      = busy_q;
    count_d     = count_q;
    map_we      = 1'b0;
    slot_we     = 1'b0;
    slot_re     = 1'b0;
    rsp_vld_d   = rsp_vld_q && !rsp_o.ready;
    rsp_stat_d  = rsp_stat_q;
    rsp_slot_d  = rsp_slot_q;
    rsp_freed_d = rsp_freed_q;
    rsp_cnt_d   = rsp_cnt_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (op_q == OP_DELETE && present_q) begin
          slot_re = 1'b1;
          state_d = S_FREE;
        end else if (can_load) begin
          rsp_vld_d   = 1'b1;
          rsp_stat_d  = ST_OK;
          rsp_slot_d  = '0;
          rsp_freed_d = '0;
          rsp_cnt_d   = FIELD_W'(count_q);
          state_d     = S_IDLE;
          case (op_q)
            OP_INSERT: begin
              if (present_q) begin
                rsp_stat_d = ST_PRESENT;
                rsp_slot_d = FIELD_W'(map_rd_q);
              end else if (ins_full) begin
                rsp_stat_d = ST_GROW;
              end else begin
                map_we           = 1'b1;
                slot_we          = 1'b1;
                map_vld_d[key_q] = 1'b1;
                busy_d[ins_slot] = 1'b1;
                count_d          = count_q + SLOT_W'(1);
                rsp_slot_d       = FIELD_W'(ins_slot);
                rsp_cnt_d        = FIELD_W'(count_q + SLOT_W'(1));
              end
            end
            OP_DELETE: begin
              rsp_stat_d = ST_ABSENT;
            end
            OP_CLEAR: begin
              map_vld_d = '0;
              busy_d    = '0;
              count_d   = '0;
              rsp_cnt_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_FREE: begin
        if (can_load) begin
          map_vld_d[key_q] = 1'b0;
          busy_d[map_rd_q] = 1'b0;
          count_d          = cnt_dec;
          rsp_vld_d        = 1'b1;
          rsp_stat_d       = (FIELD_W'(cnt_dec) < thr_q) ? ST_SHRINK : ST_OK;
          rsp_slot_d       = FIELD_W'(map_rd_q);
          rsp_freed_d      = child_rd_q;
          rsp_cnt_d        = FIELD_W'(cnt_dec);
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      map_vld_q    <= '0;
      busy_q       <= '0;
      count_q      <= '0;
      thr_q        <= SHRINK_RESET;
      first_free_q <= '0;
      rsp_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      map_vld_q    <= map_vld_d;
      busy_q       <= busy_d;
      count_q      <= count_d;
      first_free_q <= first_free_d;
      rsp_vld_q    <= rsp_vld_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  // Latch the word and look up the key map on accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= op_e'(req_i.operation);
      key_q     <= req_i.key_byte;
      child_q   <= req_i.child_ref;
      map_rd_q  <= map_mem[req_i.key_byte];
      present_q <= map_vld_q[req_i.key_byte];
    end
    if (map_we) begin
      map_mem[key_q] <= ins_slot;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_re) begin
      child_rd_q <= child_mem[map_rd_q];
    end
    if (slot_we) begin
      child_mem[ins_slot] <= child_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_stat_q  <= rsp_stat_d;
    rsp_slot_q  <= rsp_slot_d;
    rsp_freed_q <= rsp_freed_d;
    rsp_cnt_q   <= rsp_cnt_d;
  end

endmodule : radix_node48_child_table
`default_nettype wire

[tb/sv/tb_top.sv]
// Testbench: node48 child table checked word by word against a table predictor.
`timescale 1ns / 100ps
module tb_top;
  import rn48_pkg::*;

  localparam int SLOTS         = 48;
  localparam int CW            = 48;
  localparam int PHASE_WORDS   = 300;
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_CYCLES  = 20;
  localparam int HOLD_AT       = 150;
  localparam int HOLD_CYCLES   = 400;
  localparam int RUN_LIMIT_NS  = 10_000_000;

  typedef enum logic [1:0] {
    ACT_WORD   = 2'd0,
    ACT_THRESH = 2'd1,
    ACT_PACE   = 2'd2
  } act_e;

  typedef enum logic [1:0] {
    PACE_FREE  = 2'd0,
    PACE_SEND  = 2'd1,
    PACE_RECV  = 2'd2,
    PACE_BOTH  = 2'd3
  } pace_e;

  typedef struct {
    act_e            kind;
    op_e             op;
    logic [7:0]      key;
    logic [CW-1:0]   child;
    logic [5:0]      value;
  } plan_t;

  typedef struct {
    status_e         status;
    logic [5:0]      slot;
    logic [CW-1:0]   freed;
    logic [5:0]      count;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [FIELD_W-1:0] cfg_wdata_i;

  rn48_req_if #(.CHILD_WIDTH(CW)) req_if ();
  rn48_rsp_if #(.CHILD_WIDTH(CW)) rsp_if ();

  radix_node48_child_table #(
    .SLOTS       (SLOTS),
    .CHILD_WIDTH (CW)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predicted node contents
  logic [5:0]    key_slot [256];
  logic [CW-1:0] slot_ref [SLOTS];
  logic [SLOTS-1:0] slot_taken;
  int unsigned   n_children;
  logic [5:0]    shrink_below;

  // Stimulus-side view of which keys are live, used to shape sequences
  bit            gen_live [256];
  logic [7:0]    gen_keys [$];
  bit            filling;

  plan_t         op_plan_q [$];
  outcome_t      outcome_q [$];
  plan_t         word_now;
  int unsigned   words_in, words_out, errors;
  int unsigned   send_idle_pct, recv_stall_pct;
  int unsigned   settle, hold_left;
  bit            hold_done;

  function automatic void empty_table();
    for (int k = 0; k < 256; k++) key_slot[k] = 6'(SLOTS);
    slot_taken = '0;
    n_children = 0;
  endfunction

  function automatic outcome_t apply_to_table(plan_t w);
    outcome_t   r;
    logic [5:0] cur;
    bit         present;
    int         s;
    cur     = key_slot[w.key];
    present = (cur < SLOTS);
    r.status = ST_OK;
    r.slot   = '0;
    r.freed  = '0;
    case (w.op)
      OP_INSERT: begin
        if (present) begin
          r.status = ST_PRESENT;
          r.slot   = cur;
        end else begin
          s = SLOTS;
          if (n_children < SLOTS) begin
            if (!slot_taken[n_children]) s = n_children;
            else begin
              for (int i = 0; i < SLOTS; i++)
                if (s == SLOTS && !slot_taken[i]) s = i;
            end
          end
          if (s >= SLOTS) begin
            r.status = ST_GROW;
          end else begin
            slot_ref[s]   = w.child;
            slot_taken[s] = 1'b1;
            key_slot[w.key] = 6'(s);
            n_children++;
            r.slot = 6'(s);
          end
        end
      end
      OP_DELETE: begin
        if (!present) begin
          r.status = ST_ABSENT;
        end else begin
          r.freed = slot_ref[cur];
          slot_taken[cur] = 1'b0;
          key_slot[w.key] = 6'(SLOTS);
          if (n_children > 0) n_children--;
          r.slot   = cur;
          r.status = (n_children < shrink_below) ? ST_SHRINK : ST_OK;
        end
      end
      OP_CLEAR: empty_table();
      default: ;
    endcase
    r.count = 6'(n_children);
    return r;
  endfunction

  // Queue one word and track what it does to the live key set
  task automatic push_word(op_e op, logic [7:0] key, logic [CW-1:0] child);
    plan_t p;
    p.kind  = ACT_WORD;
    p.op    = op;
    p.key   = key;
    p.child = child;
    p.value = '0;
    op_plan_q.push_back(p);
    case (op)
      OP_INSERT: begin
        if (!gen_live[key] && gen_keys.size() < SLOTS) begin
          gen_live[key] = 1'b1;
          gen_keys.push_back(key);
        end
      end
      OP_DELETE: begin
        if (gen_live[key]) begin
          gen_live[key] = 1'b0;
          for (int i = gen_keys.size() - 1; i >= 0; i--)
            if (gen_keys[i] == key) gen_keys.delete(i);
        end
      end
      OP_CLEAR: begin
        for (int k = 0; k < 256; k++) gen_live[k] = 1'b0;
        gen_keys.delete();
      end
      default: ;
    endcase
  endtask

  task automatic push_ctrl(act_e kind, logic [5:0] value);
    plan_t p;
    p.kind  = kind;
    p.op    = OP_NOP;
    p.key   = '0;
    p.child = '0;
    p.value = value;
    op_plan_q.push_back(p);
  endtask

  function automatic logic [CW-1:0] random_child();
    int unsigned r;
    r = $urandom_range(15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return CW'({$urandom, $urandom});
  endfunction

  function automatic logic [7:0] pick_key(bit want_live);
    logic [7:0] k;
    if (want_live) return gen_keys[$urandom_range(gen_keys.size() - 1)];
    k = 8'($urandom_range(255));
    while (gen_live[k]) k = 8'($urandom_range(255));
    return k;
  endfunction

  // Mostly fill-then-drain sequences with random content, some noise
  task automatic random_word();
    int unsigned r;
    int unsigned n;
    n = gen_keys.size();
    if (filling && n == SLOTS && $urandom_range(3) == 0) filling = 1'b0;
    else if (!filling && n == 0) filling = 1'b1;
    else if ($urandom_range(99) < 2) filling = !filling;
    r = $urandom_range(999);
    if (r < 5) begin
      push_word(OP_CLEAR, 8'($urandom_range(255)), random_child());
    end else if (r < 20) begin
      push_word(OP_NOP, 8'($urandom_range(255)), random_child());
    end else begin
      r = $urandom_range(99);
      if (!filling) r = (r < 70) ? 90 : ((r < 82) ? 10 : ((r < 87) ? 75 : 95));
      // r: <70 new insert, <78 duplicate insert, <93 live delete, else absent delete
      if (r < 70 || (r < 78 && n == 0))
        push_word(OP_INSERT, pick_key(1'b0), random_child());
      else if (r < 78)
        push_word(OP_INSERT, pick_key(1'b1), random_child());
      else if (r < 93 && n != 0)
        push_word(OP_DELETE, pick_key(1'b1), random_child());
      else
        push_word(OP_DELETE, pick_key(1'b0), random_child());
    end
  endtask

  task automatic check_field(string name, logic [CW-1:0] want, logic [CW-1:0] got);
    if (want !== got) begin
      errors++;
      $error("%s: expected %0h, actual %0h", name, want, got);
    end
  endtask

  // Driver: present words from the plan, apply threshold writes only when idle
  always @(posedge clk_i) begin : drive_words
    logic       took;
    logic       nv;
    logic       we;
    logic [5:0] wd;
    took = req_if.valid && req_if.ready;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      cfg_we_i     <= 1'b0;
    end else begin
      nv = req_if.valid;
      we = 1'b0;
      wd = cfg_wdata_i;
      if (took) begin
        outcome_q.push_back(apply_to_table(word_now));
        words_in++;
        nv = 1'b0;
      end
      if (!nv && op_plan_q.size() != 0) begin
        case (op_plan_q[0].kind)
          ACT_PACE: begin
            case (pace_e'(op_plan_q[0].value[1:0]))
              PACE_FREE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
              PACE_SEND: begin send_idle_pct = 87; recv_stall_pct = 0;  end
              PACE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 87; end
              default:   begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            void'(op_plan_q.pop_front());
          end
          ACT_THRESH: begin
            // hold until every result is back and the pipeline has settled
            if (words_in != words_out) begin
              settle = 0;
            end else if (settle < SETTLE_CYCLES) begin
              settle++;
            end else begin
              we           = 1'b1;
              wd           = op_plan_q[0].value;
              shrink_below = op_plan_q[0].value;
              settle       = 0;
              void'(op_plan_q.pop_front());
            end
          end
          default: begin
            if ($urandom_range(99) >= send_idle_pct) begin
              word_now = op_plan_q.pop_front();
              nv = 1'b1;
            end
          end
        endcase
      end
      req_if.valid     <= nv;
      req_if.operation <= word_now.op;
      req_if.key_byte  <= word_now.key;
      req_if.child_ref <= word_now.child;
      cfg_we_i         <= we;
      cfg_wdata_i      <= wd;
    end
  end

  // Monitor: check each accepted result against the oldest prediction
  always @(posedge clk_i) begin : take_results
    outcome_t want;
    logic     rdy;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        words_out++;
        if (outcome_q.size() == 0) begin
          errors++;
          $error("result word with nothing pending: status %0d", rsp_if.status);
        end else begin
          want = outcome_q.pop_front();
          check_field("status", CW'(want.status), CW'(rsp_if.status));
          check_field("slot_used", CW'(want.slot), CW'(rsp_if.slot_used));
          check_field("freed_child", want.freed, rsp_if.freed_child);
          check_field("child_count", CW'(want.count), CW'(rsp_if.child_count));
        end
        // back up the block once while the driver keeps offering words
        if (!hold_done && words_out == HOLD_AT) begin
          hold_done = 1'b1;
          hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        rdy = ($urandom_range(99) >= recv_stall_pct);
      end
      rsp_if.ready <= rdy;
    end
  end

  initial begin : run
    logic [5:0] thr_plan [6];
    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.operation   = OP_NOP;
    req_if.key_byte    = '0;
    req_if.child_ref   = '0;
    rsp_if.ready       = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    word_now.kind      = ACT_WORD;
    word_now.op        = OP_NOP;
    word_now.key       = '0;
    word_now.child     = '0;
    word_now.value     = '0;
    words_in           = 0;
    words_out          = 0;
    errors             = 0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    settle             = 0;
    hold_left          = 0;
    hold_done          = 1'b0;
    filling            = 1'b1;
    empty_table();
    for (int s = 0; s < SLOTS; s++) slot_ref[s] = '0;
    shrink_below = SHRINK_RESET;
    for (int k = 0; k < 256; k++) gen_live[k] = 1'b0;

    push_ctrl(ACT_PACE, 6'(PACE_FREE));
    push_word(OP_NOP,    8'h5a, '1);
    push_word(OP_DELETE, 8'h00, '0);                 // delete on empty node
    push_word(OP_INSERT, 8'h00, '0);
    push_word(OP_INSERT, 8'hff, '1);
    push_word(OP_INSERT, 8'h00, 48'h1234_5678_9abc); // duplicate key
    push_word(OP_INSERT, 8'h80, 48'ha5a5_5a5a_c3c3);
    push_word(OP_DELETE, 8'hff, '0);                 // opens a hole at slot 1
    push_word(OP_INSERT, 8'h01, 48'h0000_0000_0001); // slot at count busy: lowest free
    push_word(OP_DELETE, 8'h00, '1);
    push_word(OP_INSERT, 8'h02, 48'h8000_0000_0000);
    push_word(OP_INSERT, 8'h03, 48'h7fff_ffff_ffff);
    push_word(OP_DELETE, 8'h03, '0);
    push_word(OP_DELETE, 8'h03, '0);                 // already gone
    push_word(OP_NOP,    8'h00, '0);
    push_word(OP_CLEAR,  8'haa, '1);
    push_word(OP_DELETE, 8'h80, '0);
    push_word(OP_INSERT, 8'h80, 48'hdead_beef_0042);
    push_word(OP_NOP,    8'hff, '0);

    // threshold per phase: reset value, then both ends, above the slot count
    thr_plan[0] = SHRINK_RESET;
    thr_plan[1] = 6'd0;
    thr_plan[2] = 6'd48;
    thr_plan[3] = 6'd63;
    thr_plan[4] = 6'($urandom_range(1, 47));
    thr_plan[5] = 6'd1;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph != 0) push_ctrl(ACT_THRESH, thr_plan[ph]);
      push_ctrl(ACT_PACE, (ph < 4) ? 6'(ph) : 6'($urandom_range(3)));
      for (int n = 0; n < PHASE_WORDS; n++) random_word();
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sample between edges so the driver's updates have all landed
    do begin
      @(negedge clk_i);
    end while (!(op_plan_q.size() == 0 && req_if.valid === 1'b0 &&
                 words_in == words_out));
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (outcome_q.size() != 0) begin
      errors++;
      $error("%0d predicted results never arrived", outcome_q.size());
    end
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule : tb_top

[filelist.f]
hw/rtl/rn48_pkg.sv
hw/rtl/rn48_if.sv
hw/rtl/radix_node48_child_table.sv
tb/sv/tb_top.sv
